// ----- sv/sorted_list_table_macros.svh -----
// Assertion macros shared by the sorted list table RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef SORTED_LIST_TABLE_MACROS_SVH
`define SORTED_LIST_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SLT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define SLT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/slt_pkg.sv -----
// Shared types and codes for the sorted list table.
// Used by the sequencer and the top level; depends on nothing.
package slt_pkg;

    localparam int DATA_W = 32;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int CNT_OUT_W = 5;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEL_VAL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL_MIN = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // Result of one request, apart from the entry count
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic                     head_valid;
        logic signed [DATA_W-1:0] smallest;
    } t_result;

endpackage

// ----- sv/slt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Holds the sorted entries; depends on nothing.
module slt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/slt_ctrl.sv -----
// Sequencer of the sorted list table: scans, compares and shifts entries
// through one RAM port pair. Depends on slt_pkg and the assertion macros.
`include "sorted_list_table_macros.svh"

module slt_ctrl import slt_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request side
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [FUNC_W-1:0]             i_func,
    input  logic signed [DATA_W-1:0]      i_value,
    // result side
    input  logic                          i_out_free,
    output logic                          o_res_valid,
    output t_result                       o_res,
    output logic [$clog2(CAPACITY+1)-1:0] o_count,
    // entry RAM
    output logic                          o_we,
    output logic [$clog2(CAPACITY)-1:0]   o_waddr,
    output logic [DATA_W-1:0]             o_wdata,
    output logic [$clog2(CAPACITY)-1:0]   o_raddr,
    input  logic [DATA_W-1:0]             i_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_CMP = 4'd2;
    localparam logic [3:0] S_INS_PUT = 4'd3;
    localparam logic [3:0] S_DV_RD   = 4'd4;
    localparam logic [3:0] S_DV_CMP  = 4'd5;
    localparam logic [3:0] S_SH_RD   = 4'd6;
    localparam logic [3:0] S_SH_WR   = 4'd7;
    localparam logic [3:0] S_HD_RD   = 4'd8;
    localparam logic [3:0] S_HD_CAP  = 4'd9;

    logic [3:0]               r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_idx, n_idx;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic [STAT_W-1:0]        r_status, n_status;

    logic [CW-1:0]            w_idx_ext;
    logic [CW-1:0]            w_idx_nxt;
    logic [AW-1:0]            w_idx_inc;
    logic signed [DATA_W-1:0] w_rd_s;
    logic                     w_accept;

    assign w_idx_ext = CW'(r_idx);
    assign w_idx_nxt = w_idx_ext + 1'b1;
    assign w_idx_inc = r_idx + 1'b1;
    assign w_rd_s    = $signed(i_rdata);
    assign w_accept  = i_valid && o_ready;

    assign o_ready = (r_state == S_IDLE);
    assign o_count = r_count;

    // Sequencer: one RAM read or one compare-and-move per state
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_value  = r_value;
        n_status = r_status;
        o_we     = 1'b0;
        o_waddr  = r_idx;
        o_wdata  = i_rdata;
        o_raddr  = '0;
        o_res_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_value  = i_value;
                    n_status = ST_OK;
                    n_idx    = '0;
                    n_state  = S_HD_RD;
                    case (i_func)
                        FUNC_INSERT: begin
                            if (r_count >= CAP_CNT) begin
                                n_status = ST_FULL;
                            end else if (r_count == '0) begin
                                o_we    = 1'b1;
                                o_waddr = '0;
                                o_wdata = i_value;
                                n_count = r_count + 1'b1;
                            end else begin
                                // start from the top entry and walk down
                                n_idx   = AW'(r_count - 1'b1);
                                n_state = S_INS_RD;
                            end
                        end
                        FUNC_DEL_VAL: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_DV_RD;
                            end
                        end
                        FUNC_DEL_MIN: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_SH_RD;
                            end
                        end
                        default: begin
                            // unused code: report contents unchanged
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                o_raddr = r_idx;
                n_state = S_INS_CMP;
            end
            S_INS_CMP: begin
                o_we    = 1'b1;
                o_waddr = w_idx_inc;
                if (w_rd_s > r_value) begin
                    // move the larger entry up one place
                    o_wdata = i_rdata;
                    if (r_idx == '0) begin
                        n_state = S_INS_PUT;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_INS_RD;
                    end
                end else begin
                    o_wdata = r_value;
                    n_count = r_count + 1'b1;
                    n_state = S_HD_RD;
                end
            end
            S_INS_PUT: begin
                o_we    = 1'b1;
                o_waddr = '0;
                o_wdata = r_value;
                n_count = r_count + 1'b1;
                n_state = S_HD_RD;
            end
            S_DV_RD: begin
                o_raddr = r_idx;
                n_state = S_DV_CMP;
            end
            S_DV_CMP: begin
                if (w_rd_s == r_value) begin
                    n_state = S_SH_RD;
                end else if (w_idx_nxt == r_count) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_HD_RD;
                end else begin
                    n_idx   = w_idx_inc;
                    n_state = S_DV_RD;
                end
            end
            S_SH_RD: begin
                // close the gap: pull the next entry down, or drop the tail
                if (w_idx_nxt < r_count) begin
                    o_raddr = w_idx_inc;
                    n_state = S_SH_WR;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_HD_RD;
                end
            end
            S_SH_WR: begin
                o_we    = 1'b1;
                o_waddr = r_idx;
                o_wdata = i_rdata;
                n_idx   = w_idx_inc;
                n_state = S_SH_RD;
            end
            S_HD_RD: begin
                n_state = S_HD_CAP;
            end
            S_HD_CAP: begin
                // hold until the output register can take the word
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.status     = r_status;
    assign o_res.head_valid = (r_count != '0);
    assign o_res.smallest   = (r_count != '0) ? w_rd_s : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_value  <= n_value;
        r_status <= n_status;
    end

    `SLT_ASSERT_IMP(a_cnt_cap, 1'b1, (r_count <= CAP_CNT), "entry count above capacity")
    `SLT_ASSERT_NXT(a_acc_busy, w_accept, (r_state != S_IDLE), "sequencer idle after accept")
    `SLT_ASSERT_NXT(a_cnt_step, 1'b1, ((r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1) || (r_count + 1'b1 == $past(r_count))), "entry count moved by more than one")
    `SLT_ASSERT_IMP(a_ins_room, ((r_state == S_INS_CMP) || (r_state == S_INS_PUT)), (r_count < CAP_CNT), "insert shift on a full table")
    `SLT_ASSERT_IMP(a_res_idle, o_res_valid, (n_state == S_IDLE), "result issued without return to idle")

endmodule

// ----- sv/sorted_list_table.sv -----
// Top level of the sorted list table: request and result stream ports,
// output register, entry RAM and sequencer. Depends on slt_pkg, slt_ram, slt_ctrl.
//
// Keeps up to CAPACITY signed 32-bit values in ascending order in a single-port-pair
// RAM and serves one request at a time: insert (after equal entries), delete the
// first equal value, or delete the smallest entry. Each request returns one word
// with status, entry count (modulo 32), a non-empty flag and the smallest value.
// A request occupies the sequencer for a RAM read and a compare-or-write per entry
// compared or moved (at most the entry count; a delete-value scans up to the match
// and then moves the entries above it), plus a final read of the head entry. Full or
// empty rejections skip the scan and go straight to the head read. A finished word
// waits in the output register, so the next request is taken while it is still unread.
module sorted_list_table import slt_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] func
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [4:0] count, [5] head_valid, [37:6] smallest
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [DATA_W-1:0]    w_wdata;
    logic [AW-1:0]        w_raddr;
    logic [DATA_W-1:0]    w_rdata;
    logic                 w_out_free;
    logic                 w_res_valid;
    t_result              w_res;
    logic [CW-1:0]        w_count;
    logic [CW+CNT_OUT_W-1:0] w_count_ext;

    logic                 r_out_valid;
    t_result              r_out_res;
    logic [CNT_OUT_W-1:0] r_out_cnt;

    slt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    slt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_func      (i_s_axis_tuser),
        .i_value     ($signed(i_s_axis_tdata)),
        .i_out_free  (w_out_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_count     (w_count),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    // Count is reported modulo 32
    assign w_count_ext = {{CNT_OUT_W{1'b0}}, w_count};
    assign w_out_free  = !r_out_valid || i_m_axis_tready;

    // Output register: load a finished word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_res <= w_res;
            r_out_cnt <= w_count_ext[CNT_OUT_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_res.status;
    assign o_m_axis_tdata  = {2'b00, r_out_res.smallest, r_out_res.head_valid, r_out_cnt};

endmodule
